@@ sv/tcws_pkg.sv @@
// ----------------------------------------------------------------------------
// tcws_pkg
// Shared types and codes for the three-class weighted transmit scheduler.
// ----------------------------------------------------------------------------
package tcws_pkg;

  localparam int TAG_W       = 16;
  localparam int CLS_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int LIMIT_W     = 4;
  localparam int NUM_CLASSES = 3;

  // operation codes
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_SLOT    = 1'b1;

  // priority classes
  localparam logic [CLS_W-1:0] CLS_HIGH    = 2'd0;
  localparam logic [CLS_W-1:0] CLS_MEDIUM  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_LOW     = 2'd2;
  localparam logic [CLS_W-1:0] CLS_INVALID = 2'd3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd2;
  localparam logic [LIMIT_W-1:0] BURST_MAX   = 4'hF;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NO_CHANNEL   = 3'd1,
    ST_BAD_PRIORITY = 3'd2,
    ST_FULL         = 3'd3,
    ST_EMPTY        = 3'd4,
    ST_REFUSED      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } ctrl_state_e;

  typedef struct packed {
    logic             operation;
    logic [CLS_W-1:0] priority_class;
    logic [TAG_W-1:0] package_tag;
    logic             channel_known;
    logic             link_accepts;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status_code;
    logic                sent_valid;
    logic [TAG_W-1:0]    sent_tag;
    logic [CLS_W-1:0]    sent_class;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic commit_enq;
    logic latch_pick;
    logic commit_slot;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_slot;
  } dp_status_t;

endpackage

@@ sv/tcws_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcws_ctrl
// Sequencer for one request at a time; owns the result valid flag.
// ----------------------------------------------------------------------------
module tcws_ctrl import tcws_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;
  logic        commit;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    commit     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.is_slot) begin
          // queue head read is registered, so the pick is latched and committed from S_READ
          cmd_o.latch_pick = 1'b1;
          state_d          = S_READ;
        end else if (slot_free) begin
          cmd_o.commit_enq = 1'b1;
          commit           = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_READ: begin
        if (slot_free) begin
          cmd_o.commit_slot = 1'b1;
          commit            = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/tcws_dp.sv @@
// ----------------------------------------------------------------------------
// tcws_dp
// Queue storage, pointers, burst counter, class selection and result register.
// ----------------------------------------------------------------------------
module tcws_dp import tcws_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         status_o,
  input  in_item_t           in_data_i,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_data_i,
  output out_item_t          out_data_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  in_item_t           item_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [LIMIT_W-1:0] burst_q, burst_d;
  logic [PTR_W-1:0]   head_q  [NUM_CLASSES];
  logic [PTR_W-1:0]   head_d  [NUM_CLASSES];
  logic [CNT_W-1:0]   count_q [NUM_CLASSES];
  logic [CNT_W-1:0]   count_d [NUM_CLASSES];
  logic [TAG_BITS-1:0] rd_q   [NUM_CLASSES];
  logic [CLS_W-1:0]   pick_q, pick_d;
  logic               pick_none_q, pick_none_d;
  out_item_t          out_q, out_d;

  logic               push_en;
  logic [CLS_W-1:0]   push_cls;
  logic [PTR_W-1:0]   tail;
  logic [SUM_W-1:0]   tail_sum;
  logic [TAG_BITS-1:0] push_tag;
  logic [TAG_BITS-1:0] head_tag;

  assign status_o.is_slot = (item_q.operation == OP_SLOT);
  assign push_tag         = TAG_BITS'(item_q.package_tag);
  assign push_cls         = item_q.priority_class;
  assign out_data_o       = out_q;

  // strict priority for high, weighted turn between medium and low
  always_comb begin
    pick_d      = CLS_HIGH;
    pick_none_d = 1'b0;
    if (count_q[CLS_HIGH] != '0) begin
      pick_d = CLS_HIGH;
    end else if (burst_q < limit_q && count_q[CLS_MEDIUM] != '0) begin
      pick_d = CLS_MEDIUM;
    end else if (count_q[CLS_LOW] != '0) begin
      pick_d = CLS_LOW;
    end else if (count_q[CLS_MEDIUM] != '0) begin
      pick_d = CLS_MEDIUM;
    end else begin
      pick_none_d = 1'b1;
    end
  end

  always_comb begin
    case (pick_q)
      CLS_HIGH:   head_tag = rd_q[0];
      CLS_MEDIUM: head_tag = rd_q[1];
      CLS_LOW:    head_tag = rd_q[2];
      default:    head_tag = '0;
    endcase
  end

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    burst_d  = burst_q;
    push_en  = 1'b0;
    tail     = '0;
    tail_sum = '0;
    out_d    = out_q;

    if (cmd_i.commit_enq) begin
      out_d             = '0;
      out_d.status_code = ST_OK;
      if (!item_q.channel_known) begin
        out_d.status_code = ST_NO_CHANNEL;
      end else if (push_cls == CLS_INVALID) begin
        out_d.status_code = ST_BAD_PRIORITY;
      end else if (count_q[push_cls] == CNT_W'(QUEUE_DEPTH)) begin
        out_d.status_code = ST_FULL;
      end else begin
        // tail = head + count, wrapped once
        tail_sum = SUM_W'(head_q[push_cls]) + SUM_W'(count_q[push_cls]);
        if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
          tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
        end
        tail              = PTR_W'(tail_sum);
        push_en           = 1'b1;
        count_d[push_cls] = count_q[push_cls] + CNT_W'(1);
      end
    end

    if (cmd_i.commit_slot) begin
      out_d = '0;
      if (pick_none_q) begin
        out_d.status_code = ST_EMPTY;
      end else begin
        out_d.sent_tag   = TAG_W'(head_tag);
        out_d.sent_class = pick_q;
        if (item_q.link_accepts) begin
          out_d.status_code = ST_OK;
          out_d.sent_valid  = 1'b1;
          count_d[pick_q]   = count_q[pick_q] - CNT_W'(1);
          if (head_q[pick_q] == PTR_W'(QUEUE_DEPTH - 1)) begin
            head_d[pick_q] = '0;
          end else begin
            head_d[pick_q] = head_q[pick_q] + PTR_W'(1);
          end
          if (pick_q == CLS_MEDIUM) begin
            if (burst_q != BURST_MAX) begin
              burst_d = burst_q + LIMIT_W'(1);
            end
          end else if (pick_q == CLS_LOW) begin
            burst_d = '0;
          end
        end else begin
          out_d.status_code = ST_REFUSED;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
      burst_q <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      burst_q <= burst_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.latch_pick) begin
      pick_q      <= pick_d;
      pick_none_q <= pick_none_d;
    end
    out_q <= out_d;
  end

  // one tag memory per class, head entry read every cycle
  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_queue
    logic [TAG_BITS-1:0] mem_q [QUEUE_DEPTH];

    always_ff @(posedge clk_i) begin
      if (push_en && push_cls == CLS_W'(g)) begin
        mem_q[tail] <= push_tag;
      end
      rd_q[g] <= mem_q[head_q[g]];
    end
  end

endmodule

@@ sv/three_class_weighted_tx_scheduler.sv @@
// ----------------------------------------------------------------------------
// three_class_weighted_tx_scheduler
// Strict priority for the high class, weighted turns between medium and low.
// ----------------------------------------------------------------------------
// sequence: an enqueue result is registered once the request has passed S_EXEC;
// a slot result once it has passed S_EXEC and S_READ (the registered queue read)
// flow: a new request is taken only in S_IDLE, after the last result is committed
// reset: queues empty, burst count 0, burst limit 2; tag memories not cleared
module three_class_weighted_tx_scheduler import tcws_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  tcws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  tcws_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (dp_status),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

  // only one request in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  // a package leaves a queue only with an ok status
  a_sent_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.sent_valid |-> out_data_o.status_code == ST_OK)
    else $error("sent package without ok status");

  a_class_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.sent_class != CLS_INVALID)
    else $error("result names an invalid class");

endmodule
